@@ design/ctp_pkg.sv @@
// Shared types and codes for the comma parameter tokenizer.
package ctp_pkg;

	localparam int MAX_PARAM_DEF = 64;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2c;

	localparam logic [2:0] M_LINE_START  = 3'd0;
	localparam logic [2:0] M_AFTER_COMMA = 3'd1;
	localparam logic [2:0] M_UNQUOTED    = 3'd2;
	localparam logic [2:0] M_QUOTED      = 3'd3;
	localparam logic [2:0] M_QUOTE_SEEN  = 3'd4;
	localparam logic [2:0] M_AFTER_QUOTE = 3'd5;

	localparam logic [1:0] K_CHAR  = 2'd0;
	localparam logic [1:0] K_END   = 2'd1;
	localparam logic [1:0] K_EMPTY = 2'd2;
	localparam logic [1:0] K_EOL   = 2'd3;

	localparam logic [1:0] LB_NONE = 2'd0;
	localparam logic [1:0] LB_CR   = 2'd1;
	localparam logic [1:0] LB_LF   = 2'd2;

	// Work for the back end, emitted in field order: marker, spaces, char, end of line.
	typedef struct packed {
		logic       fin_v;
		logic       fin_empty;
		logic       fin_ovf;
		logic [5:0] sp_cnt;
		logic       ch_v;
		logic [7:0] ch;
		logic       eol_v;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [5:0] kept;
		logic [5:0] pend;
		logic       ovf;
		logic [1:0] lb;
	} scan_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

@@ design/ctp_front.sv @@
// Front end: accepts characters, tracks parameter state and builds commands.
module ctp_front #(
	parameter int MAX_PARAM = ctp_pkg::MAX_PARAM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	input  logic               char_valid,
	output logic               char_ready,
	input  logic [7:0]         char_code,
	input  ctp_pkg::queue_stat_t q_stat,
	output logic               push,
	output ctp_pkg::cmd_t      cmd
);
	import ctp_pkg::*;

	scan_state_t st_q, nxt;
	logic [6:0]  cap_q;
	logic [6:0]  cap_clamp;
	logic [6:0]  limit;
	logic        room;
	logic        eol;
	logic [1:0]  lb_code;
	logic        bw;
	logic [2:0]  bmode;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 7'(MAX_PARAM);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign cap_clamp = (cap_q > 7'(MAX_PARAM)) ? 7'(MAX_PARAM) : cap_q;
	assign limit     = (cap_clamp == 7'd0) ? 7'd0 : cap_clamp - 7'd1;
	assign room      = ({1'b0, st_q.kept} + {1'b0, st_q.pend}) < limit;
	assign eol       = (char_code == CH_NUL) || (char_code == CH_CR) || (char_code == CH_LF);
	assign lb_code   = (char_code == CH_CR) ? LB_CR : ((char_code == CH_LF) ? LB_LF : LB_NONE);

	assign char_ready = !q_stat.full;
	assign accept     = char_valid && char_ready;

	always_comb begin
		nxt   = st_q;
		cmd   = '0;
		bw    = 1'b0;
		bmode = st_q.mode;
		nxt.lb = LB_NONE;
		// drop the partner of a CR or LF that just ended a line
		if (!((st_q.lb == LB_CR && char_code == CH_LF) ||
		      (st_q.lb == LB_LF && char_code == CH_CR))) begin
			case (st_q.mode)
				M_UNQUOTED: begin
					if (eol || char_code == CH_COMMA) begin
						cmd.fin_v     = 1'b1;
						cmd.fin_empty = (st_q.kept == 6'd0);
						cmd.fin_ovf   = st_q.ovf;
						nxt.kept = '0;
						nxt.pend = '0;
						nxt.ovf  = 1'b0;
						if (eol) begin
							cmd.eol_v = 1'b1;
							nxt.mode  = M_LINE_START;
							nxt.lb    = lb_code;
						end else begin
							nxt.mode = M_AFTER_COMMA;
						end
					end else if (char_code == CH_SPACE) begin
						if (room) nxt.pend = st_q.pend + 6'd1;
					end else if (room) begin
						// release held spaces ahead of the character
						cmd.sp_cnt = st_q.pend;
						cmd.ch_v   = 1'b1;
						cmd.ch     = char_code;
						nxt.kept   = st_q.kept + st_q.pend + 6'd1;
						nxt.pend   = '0;
					end
				end
				M_QUOTED: begin
					if (eol) begin
						cmd.fin_v     = 1'b1;
						cmd.fin_empty = (st_q.kept == 6'd0);
						cmd.fin_ovf   = st_q.ovf;
						cmd.eol_v     = 1'b1;
						nxt.kept = '0;
						nxt.pend = '0;
						nxt.ovf  = 1'b0;
						nxt.mode = M_LINE_START;
						nxt.lb   = lb_code;
					end else if (char_code == CH_QUOTE) begin
						nxt.mode = M_QUOTE_SEEN;
					end else if ({1'b0, st_q.kept} < limit) begin
						cmd.ch_v = 1'b1;
						cmd.ch   = char_code;
						nxt.kept = st_q.kept + 6'd1;
					end else begin
						nxt.ovf = 1'b1;
					end
				end
				M_QUOTE_SEEN: begin
					if (char_code == CH_QUOTE) begin
						nxt.mode = M_QUOTED;
						if ({1'b0, st_q.kept} < limit) begin
							cmd.ch_v = 1'b1;
							cmd.ch   = char_code;
							nxt.kept = st_q.kept + 6'd1;
						end else begin
							nxt.ovf = 1'b1;
						end
					end else begin
						cmd.fin_v     = 1'b1;
						cmd.fin_empty = (st_q.kept == 6'd0);
						cmd.fin_ovf   = st_q.ovf;
						nxt.kept = '0;
						nxt.pend = '0;
						nxt.ovf  = 1'b0;
						bw    = 1'b1;
						bmode = M_AFTER_QUOTE;
					end
				end
				M_AFTER_COMMA, M_AFTER_QUOTE: begin
					bw = 1'b1;
				end
				default: begin
					bw    = 1'b1;
					bmode = M_LINE_START;
				end
			endcase

			// between parameters
			if (bw) begin
				nxt.mode = bmode;
				if (eol) begin
					if (bmode == M_AFTER_COMMA) begin
						cmd.fin_v     = 1'b1;
						cmd.fin_empty = (st_q.kept == 6'd0);
						cmd.fin_ovf   = st_q.ovf;
						nxt.kept = '0;
						nxt.pend = '0;
						nxt.ovf  = 1'b0;
					end
					cmd.eol_v = 1'b1;
					nxt.mode  = M_LINE_START;
					nxt.lb    = lb_code;
				end else if (char_code == CH_SPACE || char_code == CH_TAB) begin
					nxt.mode = bmode;
				end else if (char_code == CH_COMMA) begin
					if (bmode != M_AFTER_QUOTE) begin
						cmd.fin_v     = 1'b1;
						cmd.fin_empty = (st_q.kept == 6'd0);
						cmd.fin_ovf   = st_q.ovf;
						nxt.kept = '0;
						nxt.pend = '0;
						nxt.ovf  = 1'b0;
					end
					nxt.mode = M_AFTER_COMMA;
				end else begin
					nxt.kept = '0;
					nxt.pend = '0;
					nxt.ovf  = 1'b0;
					if (char_code == CH_QUOTE) begin
						nxt.mode = M_QUOTED;
					end else begin
						nxt.mode = M_UNQUOTED;
						if (limit != 7'd0) begin
							cmd.ch_v = 1'b1;
							cmd.ch   = char_code;
							nxt.kept = 6'd1;
						end
					end
				end
			end
		end
	end

	assign push = accept && (cmd.fin_v || cmd.ch_v || cmd.eol_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode <= M_LINE_START;
			st_q.kept <= '0;
			st_q.pend <= '0;
			st_q.ovf  <= 1'b0;
			st_q.lb   <= LB_NONE;
		end else if (accept) begin
			st_q <= nxt;
		end
	end

endmodule

@@ design/ctp_queue.sv @@
// Short command queue between the front and back ends.
module ctp_queue #(
	parameter int DEPTH = ctp_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ctp_pkg::cmd_t        wr_cmd,
	input  logic                 pop,
	output ctp_pkg::cmd_t        rd_cmd,
	output ctp_pkg::queue_stat_t stat
);
	import ctp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

@@ design/ctp_back.sv @@
// Back end: expands commands into result words through an output register.
module ctp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctp_pkg::cmd_t        head,
	input  ctp_pkg::queue_stat_t q_stat,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [7:0]           out_char,
	output logic [1:0]           kind,
	output logic                 overflow,
	output logic                 last
);
	import ctp_pkg::*;

	cmd_t       cur_q;
	logic       cur_valid_q;
	cmd_t       rest;
	logic [7:0] it_char;
	logic [1:0] it_kind;
	logic       it_ovf;
	logic       it_last;
	logic       load;
	logic       res_valid_q;
	logic [7:0] out_char_q;
	logic [1:0] kind_q;
	logic       overflow_q;
	logic       last_q;

	// pick the next piece and clear it from the working copy
	always_comb begin
		rest    = cur_q;
		it_char = 8'd0;
		it_ovf  = 1'b0;
		if (cur_q.fin_v) begin
			rest.fin_v = 1'b0;
			it_kind    = cur_q.fin_empty ? K_EMPTY : K_END;
			it_ovf     = cur_q.fin_ovf;
		end else if (cur_q.sp_cnt != 6'd0) begin
			rest.sp_cnt = cur_q.sp_cnt - 6'd1;
			it_kind     = K_CHAR;
			it_char     = CH_SPACE;
		end else if (cur_q.ch_v) begin
			rest.ch_v = 1'b0;
			it_kind   = K_CHAR;
			it_char   = cur_q.ch;
		end else begin
			rest.eol_v = 1'b0;
			it_kind    = K_EOL;
		end
		it_last = !rest.fin_v && (rest.sp_cnt == 6'd0) && !rest.ch_v && !rest.eol_v;
	end

	assign load = cur_valid_q && (!res_valid_q || res_ready);
	assign pop  = !q_stat.empty && (!cur_valid_q || (load && it_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (load && it_last) begin
				cur_valid_q <= 1'b0;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end else if (load) begin
			cur_q <= rest;
		end
		if (load) begin
			out_char_q <= it_char;
			kind_q     <= it_kind;
			overflow_q <= it_ovf;
			last_q     <= it_last;
		end
	end

	assign res_valid = res_valid_q;
	assign out_char  = out_char_q;
	assign kind      = kind_q;
	assign overflow  = overflow_q;
	assign last      = last_q;

endmodule

@@ design/comma_parameter_tokenizer.sv @@
// Top level of the comma parameter tokenizer.
//
//   channel   direction  handshake               payload
//   char      in         char_valid/char_ready   char_code
//   result    out        res_valid/res_ready     out_char, kind, overflow, last
//   cfg       in         cfg_we                  cfg_wdata (param_capacity)
//
// One character is accepted per cycle while the four-entry command queue has room.
// While res_ready is high and work waits, the back end sends one result word per cycle;
// a character that releases n held spaces gives n+1 words, a parameter end with end of
// line gives two. The output register takes a new word whenever the old one is taken
// or absent. arst_n resets all control state; char_ready is high out of reset.
module comma_parameter_tokenizer #(
	parameter int MAX_PARAM = ctp_pkg::MAX_PARAM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] char_code,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] out_char,
	output logic [1:0] kind,
	output logic       overflow,
	output logic       last
);
	import ctp_pkg::*;

	cmd_t        wr_cmd;
	cmd_t        rd_cmd;
	logic        push;
	logic        pop;
	queue_stat_t q_stat;

	ctp_front #(
		.MAX_PARAM (MAX_PARAM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_code  (char_code),
		.q_stat     (q_stat),
		.push       (push),
		.cmd        (wr_cmd)
	);

	ctp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.stat   (q_stat)
	);

	ctp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (rd_cmd),
		.q_stat    (q_stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_char  (out_char),
		.kind      (kind),
		.overflow  (overflow),
		.last      (last)
	);

endmodule

@@ design/ctp_checker.sv @@
// Port checks for the comma parameter tokenizer and their binding.
module ctp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_char,
	input logic [1:0] kind,
	input logic       overflow,
	input logic       last
);
	import ctp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_char) && $stable(kind) &&
			$stable(overflow) && $stable(last))
		else $error("result word changed while stalled");

	a_char_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == K_CHAR |-> !overflow)
		else $error("overflow on a character word");

	a_eol_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == K_EOL |-> last && !overflow)
		else $error("end of line is not the final word");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != K_CHAR |-> out_char == 8'd0)
		else $error("marker word carries a character");

endmodule

bind comma_parameter_tokenizer ctp_checker u_ctp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.out_char  (out_char),
	.kind      (kind),
	.overflow  (overflow),
	.last      (last)
);
